@@ design/ffha_pkg.sv @@
// ============================================================================
// ffha_pkg
// Shared types and constants of the first-fit boundary-tag heap allocator.
// ============================================================================
package ffha_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = 12;
    localparam int MAX_PAGES  = 16;
    localparam int TAG_WORDS  = (PAGE_BYTES / 4) * MAX_PAGES;
    localparam int TAG_AW     = $clog2(TAG_WORDS);
    localparam int TAG_W      = 18;
    localparam int NEED_W     = 28;
    localparam int ALLOC_MAX  = 64 * 1024 * 1024;
    localparam int TAG_OVH    = 8;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_BIG  = 2'd1,
        ST_NO_MEM   = 2'd2,
        ST_IGNORED  = 2'd3
    } status_t;

    typedef struct packed {
        logic              we;
        logic [TAG_AW-1:0] addr;
        logic [TAG_W-1:0]  wdata;
    } tag_req_t;

    function automatic logic [TAG_W-1:0] tag_size(input logic [TAG_W-1:0] w);
        tag_size = {w[TAG_W-1:2], 2'b00};
    endfunction

    function automatic logic [TAG_AW-1:0] word_of(input logic [TAG_W-1:0] b);
        word_of = b[TAG_AW+1:2];
    endfunction

endpackage

@@ design/first_fit_heap_allocator_unit.sv @@
// ============================================================================
// first_fit_heap_allocator_unit
// First-fit allocator over a boundary-tag heap held in one tag memory.
// ============================================================================
// Allocate and free walk the heap block by block; a too large request or a null
//   free is answered without a walk. Every step uses the single tag memory port,
//   one tag access per cycle, with registered read data.
// Throughput: one item at a time; the next item is taken the cycle after the
//   result is registered, which waits while the output holds an unaccepted item.
// Reset: the initial free block and end sentinel are written by the init states;
//   no item is taken until then. page_limit resets to 16.
module first_fit_heap_allocator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [26:0] request_bytes,
    input  logic [15:0] block_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] result_address,
    output logic [1:0]  status,
    output logic [4:0]  pages_in_use
);

    localparam int W  = ffha_pkg::TAG_W;
    localparam int NW = ffha_pkg::NEED_W;

    typedef enum logic [4:0] {
        S_INIT0, S_INIT1, S_INIT2, S_INIT3, S_IDLE,
        S_A_RD, S_A_EV, S_TK_H1, S_TK_F1, S_TK_H2, S_TK_F2,
        S_T_RD, S_T_EV, S_G_CK, S_G_H, S_G_F, S_S_H, S_S_F,
        S_F_RD, S_F_EV, S_F_NX, S_F_NXEV, S_F_PV, S_F_PVEV,
        S_F_PPRD, S_F_PPEV, S_F_H, S_F_F, S_DONE
    } state_t;

    state_t                state_reg;
    logic [W-1:0]          p_reg, s_reg, q_reg;
    logic [NW-1:0]         need_reg, want_reg;
    logic                  tfree_reg;
    logic [4:0]            k_reg;
    logic [4:0]            pages_reg, limit_reg;
    logic [15:0]           res_addr_reg, out_addr_reg;
    ffha_pkg::status_t     res_status_reg, out_status_reg;
    logic                  out_valid_reg;
    logic [4:0]            out_pages_reg;
    logic                  req_type_reg;
    logic [15:0]           free_addr_reg;

    ffha_pkg::tag_req_t    mreq;
    logic [W-1:0]          rdata;

    ffha_tag_ram u_ram (
        .clk   (clk),
        .req   (mreq),
        .rdata (rdata)
    );

    logic [W-1:0]  end_w, rd_size, ts_w, ovh;
    logic [W:0]    ts_plus;
    logic [NW-1:0] need_in, diff, k_full;
    logic          split;
    logic [4:0]    lim;
    logic [W-1:0]  nx_w, pp_w, grow_sz, grow_t, new_end;

    always_comb
    begin
        ovh      = W'(ffha_pkg::TAG_OVH);
        end_w    = (W'(pages_reg) << ffha_pkg::PAGE_SHIFT) - W'(4);
        rd_size  = ffha_pkg::tag_size(rdata);
        ts_w     = rd_size;
        ts_plus  = {1'b0, ts_w} + (W+1)'(4);
        need_in  = ({1'b0, request_bytes} + NW'(11)) & ~NW'(3);
        diff     = NW'(s_reg) - need_reg;
        split    = (NW'(s_reg) >= need_reg) && (diff >= NW'(ffha_pkg::TAG_OVH));
        k_full   = (want_reg + NW'(ffha_pkg::PAGE_BYTES - 1)) >> ffha_pkg::PAGE_SHIFT;
        lim      = (limit_reg > 5'(ffha_pkg::MAX_PAGES)) ? 5'(ffha_pkg::MAX_PAGES)
                                                         : limit_reg;
        nx_w     = p_reg + s_reg;
        pp_w     = W'(free_addr_reg) - q_reg;
        grow_sz  = (tfree_reg ? q_reg : W'(0)) + (W'(k_full[4:0]) << ffha_pkg::PAGE_SHIFT);
        grow_t   = tfree_reg ? (end_w - q_reg) : end_w;
        new_end  = end_w;
    end

    always_comb
    begin
        mreq = '0;
        unique case (state_reg)
            S_INIT0:
            begin
                mreq.we    = 1'b1;
                mreq.addr  = ffha_pkg::word_of(W'(0));
                mreq.wdata = W'(ffha_pkg::PAGE_BYTES - ffha_pkg::TAG_OVH);
            end
            S_INIT1:
            begin
                mreq.we    = 1'b1;
                mreq.addr  = ffha_pkg::word_of(W'(ffha_pkg::PAGE_BYTES - 12));
                mreq.wdata = W'(ffha_pkg::PAGE_BYTES - ffha_pkg::TAG_OVH);
            end
            S_INIT2:
            begin
                mreq.we    = 1'b1;
                mreq.addr  = ffha_pkg::word_of(W'(ffha_pkg::PAGE_BYTES - 8));
                mreq.wdata = ovh | W'(1);
            end
            S_INIT3:
            begin
                mreq.we    = 1'b1;
                mreq.addr  = ffha_pkg::word_of(W'(ffha_pkg::PAGE_BYTES - 4));
                mreq.wdata = ovh | W'(1);
            end
            S_A_RD, S_F_RD:
            begin
                mreq.addr = ffha_pkg::word_of(p_reg - W'(4));
            end
            S_T_RD:
            begin
                mreq.addr = ffha_pkg::word_of(end_w - ovh);
            end
            S_TK_H1:
            begin
                mreq.we    = 1'b1;
                mreq.addr  = ffha_pkg::word_of(p_reg - W'(4));
                mreq.wdata = (split ? need_reg[W-1:0] : s_reg) | W'(1);
            end
            S_TK_F1:
            begin
                mreq.we    = 1'b1;
                mreq.addr  = ffha_pkg::word_of(split ? (p_reg + need_reg[W-1:0] - ovh)
                                                     : (p_reg + s_reg - ovh));
                mreq.wdata = (split ? need_reg[W-1:0] : s_reg) | W'(1);
            end
            S_TK_H2:
            begin
                mreq.we    = 1'b1;
                mreq.addr  = ffha_pkg::word_of(p_reg + need_reg[W-1:0] - W'(4));
                mreq.wdata = diff[W-1:0];
            end
            S_TK_F2:
            begin
                mreq.we    = 1'b1;
                mreq.addr  = ffha_pkg::word_of(p_reg + s_reg - ovh);
                mreq.wdata = diff[W-1:0];
            end
            S_G_H, S_F_H:
            begin
                mreq.we    = 1'b1;
                mreq.addr  = ffha_pkg::word_of(p_reg - W'(4));
                mreq.wdata = s_reg;
            end
            S_G_F, S_F_F:
            begin
                mreq.we    = 1'b1;
                mreq.addr  = ffha_pkg::word_of(p_reg + s_reg - ovh);
                mreq.wdata = s_reg;
            end
            S_S_H:
            begin
                mreq.we    = 1'b1;
                mreq.addr  = ffha_pkg::word_of(new_end - W'(4));
                mreq.wdata = ovh | W'(1);
            end
            S_S_F:
            begin
                mreq.we    = 1'b1;
                mreq.addr  = ffha_pkg::word_of(new_end);
                mreq.wdata = ovh | W'(1);
            end
            S_F_NX:
            begin
                mreq.addr = ffha_pkg::word_of(nx_w - W'(4));
            end
            S_F_PV:
            begin
                mreq.addr = ffha_pkg::word_of(p_reg - ovh);
            end
            S_F_PPRD:
            begin
                mreq.addr = ffha_pkg::word_of(pp_w - W'(4));
            end
            default:
            begin
                mreq = '0;
            end
        endcase
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign result_address = out_addr_reg;
    assign status         = out_status_reg;
    assign pages_in_use   = out_pages_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT0;
            pages_reg      <= 5'd1;
            limit_reg      <= 5'd16;
            out_valid_reg  <= 1'b0;
            tfree_reg      <= 1'b0;
            req_type_reg   <= 1'b0;
            res_status_reg <= ffha_pkg::ST_OK;
            out_status_reg <= ffha_pkg::ST_OK;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT0: state_reg <= S_INIT1;
                S_INIT1: state_reg <= S_INIT2;
                S_INIT2: state_reg <= S_INIT3;
                S_INIT3: state_reg <= S_IDLE;
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_type_reg  <= req_type;
                        free_addr_reg <= block_address;
                        need_reg      <= need_in;
                        p_reg         <= W'(4);
                        res_addr_reg  <= 16'd0;
                        if (req_type)
                        begin
                            if (block_address == 16'd0)
                            begin
                                res_status_reg <= ffha_pkg::ST_IGNORED;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_F_RD;
                            end
                        end
                        else if (need_in > NW'(ffha_pkg::ALLOC_MAX))
                        begin
                            res_status_reg <= ffha_pkg::ST_TOO_BIG;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_A_RD;
                        end
                    end
                end
                S_A_RD:
                begin
                    state_reg <= (p_reg >= end_w) ? S_T_RD : S_A_EV;
                end
                S_A_EV:
                begin
                    if (!rdata[0] && (NW'(rd_size) >= need_reg))
                    begin
                        s_reg     <= rd_size;
                        state_reg <= S_TK_H1;
                    end
                    else if (rd_size < ovh)
                    begin
                        state_reg <= S_T_RD;
                    end
                    else
                    begin
                        p_reg     <= p_reg + rd_size;
                        state_reg <= S_A_RD;
                    end
                end
                S_TK_H1: state_reg <= S_TK_F1;
                S_TK_F1:
                begin
                    if (split)
                    begin
                        state_reg <= S_TK_H2;
                    end
                    else
                    begin
                        res_addr_reg   <= p_reg[15:0];
                        res_status_reg <= ffha_pkg::ST_OK;
                        state_reg      <= S_DONE;
                    end
                end
                S_TK_H2: state_reg <= S_TK_F2;
                S_TK_F2:
                begin
                    res_addr_reg   <= p_reg[15:0];
                    res_status_reg <= ffha_pkg::ST_OK;
                    state_reg      <= S_DONE;
                end
                S_T_RD: state_reg <= S_T_EV;
                S_T_EV:
                begin
                    tfree_reg <= !rdata[0] && (ts_w >= ovh) && (NW'(ts_w) < need_reg)
                                 && (ts_plus <= {1'b0, end_w});
                    q_reg     <= ts_w;
                    if (!rdata[0] && (ts_w >= ovh) && (NW'(ts_w) < need_reg)
                        && (ts_plus <= {1'b0, end_w}))
                    begin
                        want_reg <= need_reg - NW'(ts_w);
                    end
                    else
                    begin
                        want_reg <= need_reg;
                    end
                    state_reg <= S_G_CK;
                end
                S_G_CK:
                begin
                    if ((lim < pages_reg) || (k_full > NW'(lim - pages_reg)))
                    begin
                        res_status_reg <= ffha_pkg::ST_NO_MEM;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        k_reg     <= k_full[4:0];
                        p_reg     <= grow_t;
                        s_reg     <= grow_sz;
                        state_reg <= S_G_H;
                    end
                end
                S_G_H: state_reg <= S_G_F;
                S_G_F:
                begin
                    pages_reg <= pages_reg + k_reg;
                    state_reg <= S_S_H;
                end
                S_S_H: state_reg <= S_S_F;
                S_S_F: state_reg <= S_TK_H1;
                S_F_RD:
                begin
                    if (p_reg >= end_w)
                    begin
                        res_status_reg <= ffha_pkg::ST_IGNORED;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_F_EV;
                    end
                end
                S_F_EV:
                begin
                    if (p_reg == W'(free_addr_reg))
                    begin
                        if (rdata[0])
                        begin
                            s_reg     <= rd_size;
                            state_reg <= S_F_NX;
                        end
                        else
                        begin
                            res_status_reg <= ffha_pkg::ST_IGNORED;
                            state_reg      <= S_DONE;
                        end
                    end
                    else if (rd_size < ovh)
                    begin
                        res_status_reg <= ffha_pkg::ST_IGNORED;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        p_reg     <= p_reg + rd_size;
                        state_reg <= S_F_RD;
                    end
                end
                S_F_NX:
                begin
                    state_reg <= (nx_w < end_w) ? S_F_NXEV : S_F_PV;
                end
                S_F_NXEV:
                begin
                    if (!rdata[0])
                    begin
                        s_reg <= s_reg + rd_size;
                    end
                    state_reg <= S_F_PV;
                end
                S_F_PV:
                begin
                    state_reg <= (p_reg > W'(4)) ? S_F_PVEV : S_F_H;
                end
                S_F_PVEV:
                begin
                    q_reg <= rd_size;
                    if ((rd_size >= ovh) && (rd_size < p_reg))
                    begin
                        state_reg <= S_F_PPRD;
                    end
                    else
                    begin
                        state_reg <= S_F_H;
                    end
                end
                S_F_PPRD: state_reg <= S_F_PPEV;
                S_F_PPEV:
                begin
                    if (!rdata[0])
                    begin
                        p_reg <= pp_w;
                        s_reg <= s_reg + q_reg;
                    end
                    state_reg <= S_F_H;
                end
                S_F_H: state_reg <= S_F_F;
                S_F_F:
                begin
                    res_status_reg <= ffha_pkg::ST_OK;
                    state_reg      <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_addr_reg   <= req_type_reg ? 16'd0 : res_addr_reg;
                        out_status_reg <= res_status_reg;
                        out_pages_reg  <= pages_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ design/ffha_tag_ram.sv @@
// ============================================================================
// ffha_tag_ram
// Single-port tag memory, one word per 4 heap bytes, registered read data.
// ============================================================================
module ffha_tag_ram (
    input  logic                        clk,
    input  ffha_pkg::tag_req_t          req,
    output logic [ffha_pkg::TAG_W-1:0]  rdata
);

    logic [ffha_pkg::TAG_W-1:0] mem [ffha_pkg::TAG_WORDS];
    logic [ffha_pkg::TAG_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// First-fit heap allocator testbench
// Drives allocate and free requests with random idling on both sides and
// checks every result against a boundary-tag heap model kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0]       addr;
        ffha_pkg::status_t st;
        logic [4:0]        pages;
    } heap_reply_t;

    class heap_scoreboard;
        int unsigned tags[ffha_pkg::TAG_WORDS];
        int unsigned pages;
        int unsigned limit;
        heap_reply_t replies[$];
        int unsigned live[$];
        int          errors;

        function new();
            foreach (tags[i]) tags[i] = 0;
            pages  = 1;
            limit  = 16;
            errors = 0;
            put_tag(4, ffha_pkg::PAGE_BYTES - ffha_pkg::TAG_OVH, 0);
            put_tag(top_off(), ffha_pkg::TAG_OVH, 1);
        endfunction

        function int unsigned rd(int unsigned b);
            return ((b >> 2) < ffha_pkg::TAG_WORDS) ? tags[b >> 2] : 0;
        endfunction

        function void wr(int unsigned b, int unsigned v);
            if ((b >> 2) < ffha_pkg::TAG_WORDS) tags[b >> 2] = v;
        endfunction

        function int unsigned bsize(int unsigned p);
            return (p < 4) ? 0 : (rd(p - 4) & ~32'd3);
        endfunction

        function bit bused(int unsigned p);
            return (p < 4) ? 1'b1 : ((rd(p - 4) & 32'd1) != 0);
        endfunction

        function void put_tag(int unsigned p, int unsigned s, bit u);
            if (p < 4 || s < ffha_pkg::TAG_OVH) return;
            wr(p - 4, s | u);
            wr(p + s - ffha_pkg::TAG_OVH, s | u);
        endfunction

        function int unsigned top_off();
            return pages * ffha_pkg::PAGE_BYTES - 4;
        endfunction

        function void take(int unsigned p, int unsigned need);
            int unsigned s;
            s = bsize(p);
            if (s >= need && s - need >= ffha_pkg::TAG_OVH)
            begin
                put_tag(p, need, 1);
                put_tag(p + need, s - need, 0);
            end
            else
                put_tag(p, s, 1);
        endfunction

        function ffha_pkg::status_t alloc(int unsigned req, output int unsigned a);
            int unsigned need, last_off, p, s, tw, ts, want, k, lim, t;
            bit tfree;
            a = 0;
            need = (req + ffha_pkg::TAG_OVH + 3) & ~32'd3;
            last_off = top_off();
            p = 4;
            if (need > ffha_pkg::ALLOC_MAX) return ffha_pkg::ST_TOO_BIG;
            while (p < last_off)
            begin
                s = bsize(p);
                if (!bused(p) && s >= need)
                begin
                    take(p, need);
                    a = p;
                    return ffha_pkg::ST_OK;
                end
                if (s < ffha_pkg::TAG_OVH) break;
                p += s;
            end
            tw = rd(last_off - ffha_pkg::TAG_OVH);
            ts = tw & ~32'd3;
            tfree = !tw[0] && ts >= ffha_pkg::TAG_OVH && ts < need && ts + 4 <= last_off;
            want = tfree ? need - ts : need;
            k = (want + ffha_pkg::PAGE_BYTES - 1) / ffha_pkg::PAGE_BYTES;
            lim = (limit > ffha_pkg::MAX_PAGES) ? ffha_pkg::MAX_PAGES : limit;
            if (lim < pages || k > lim - pages) return ffha_pkg::ST_NO_MEM;
            if (tfree)
            begin
                t = last_off - ts;
                put_tag(t, ts + k * ffha_pkg::PAGE_BYTES, 0);
            end
            else
            begin
                t = last_off;
                put_tag(t, k * ffha_pkg::PAGE_BYTES, 0);
            end
            pages += k;
            put_tag(top_off(), ffha_pkg::TAG_OVH, 1);
            take(t, need);
            a = t;
            return ffha_pkg::ST_OK;
        endfunction

        function ffha_pkg::status_t release_block(int unsigned a);
            int unsigned last_off, p, s, nx, ps, pp;
            bit hit;
            last_off = top_off();
            p = 4;
            hit = 0;
            if (a == 0) return ffha_pkg::ST_IGNORED;
            while (p < last_off)
            begin
                s = bsize(p);
                if (p == a)
                begin
                    hit = 1;
                    break;
                end
                if (s < ffha_pkg::TAG_OVH) break;
                p += s;
            end
            if (!hit || !bused(a)) return ffha_pkg::ST_IGNORED;
            s = bsize(a);
            nx = a + s;
            if (nx < last_off && !bused(nx)) s += bsize(nx);
            if (a > 4)
            begin
                ps = rd(a - ffha_pkg::TAG_OVH) & ~32'd3;
                if (ps >= ffha_pkg::TAG_OVH && ps < a)
                begin
                    pp = a - ps;
                    if (!bused(pp))
                    begin
                        a = pp;
                        s += ps;
                    end
                end
            end
            put_tag(a, s, 0);
            return ffha_pkg::ST_OK;
        endfunction

        function void note(bit rt, int unsigned rb, int unsigned ba);
            heap_reply_t r;
            int unsigned a;
            a = 0;
            if (rt)
            begin
                r.st = release_block(ba);
                if (r.st == ffha_pkg::ST_OK)
                    foreach (live[i])
                        if (live[i] == ba)
                        begin
                            live.delete(i);
                            break;
                        end
            end
            else
            begin
                r.st = alloc(rb, a);
                if (r.st == ffha_pkg::ST_OK) live.push_back(a);
            end
            r.addr  = a[15:0];
            r.pages = pages[4:0];
            replies.push_back(r);
        endfunction

        function void check(logic [15:0] addr, logic [1:0] st, logic [4:0] pg);
            heap_reply_t e;
            if (replies.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result addr=%0d status=%0d", addr, st);
                return;
            end
            e = replies.pop_front();
            if (addr !== e.addr || st !== e.st || pg !== e.pages)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp addr=%0d status=%0d pages=%0d, got %0d %0d %0d",
                             e.addr, e.st, e.pages, addr, st, pg);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_wr_en = 0;
    logic [4:0]  cfg_wr_data = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic        req_type = 0;
    logic [26:0] request_bytes = 0;
    logic [15:0] block_address = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [15:0] result_address;
    logic [1:0]  status;
    logic [4:0]  pages_in_use;

    heap_scoreboard sb = new();
    bit idle_on = 1;
    int hold_left = 0;

    first_fit_heap_allocator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .request_bytes(request_bytes),
        .block_address(block_address),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_address(result_address), .status(status),
        .pages_in_use(pages_in_use)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    initial
    begin
        #200ms;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check(result_address, status, pages_in_use);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 0;
            end
            else
                out_ready <= !(idle_on && $urandom_range(99) < 20);
        end
    end

    task automatic send(bit rt, int unsigned rb, int unsigned ba);
        if (idle_on && $urandom_range(99) < 20)
        begin
            in_valid <= 0;
            do @(posedge clk); while ($urandom_range(99) < 50);
        end
        in_valid      <= 1;
        req_type      <= rt;
        request_bytes <= rb[26:0];
        block_address <= ba[15:0];
        do @(posedge clk); while (!in_ready);
        sb.note(rt, rb[26:0], ba[15:0]);
    endtask

    task automatic write_limit(int unsigned v);
        in_valid <= 0;
        while (sb.replies.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        cfg_wr_en   <= 1;
        cfg_wr_data <= v[4:0];
        @(posedge clk);
        cfg_wr_en <= 0;
        sb.limit = v & 31;
    endtask

    task automatic random_item();
        int unsigned r, sz;
        r = $urandom_range(99);
        if (sb.live.size() > 0 && (r < 40 || sb.live.size() > 40))
            send(1, $urandom, sb.live[$urandom_range(sb.live.size() - 1)]);
        else if (r < 45)
            send(1, $urandom, $urandom_range(65535));
        else if (r < 48)
            send(0, $urandom, 0);
        else
        begin
            sz = ($urandom_range(19) == 0) ? $urandom_range(9000) : $urandom_range(300);
            send(0, sz, $urandom);
        end
    endtask

    initial
    begin
        int unsigned lims[4] = '{1, 4, 16, 31};
        repeat (8) @(posedge clk);
        rst_n <= 1;
        write_limit(1);
        send(0, 0, 0);
        send(0, 67108864, 0);
        send(0, 67108856, 0);
        send(0, 27'h7FFFFFF, 16'hFFFF);
        send(0, 5000, 0);
        send(0, 4070, 0);
        send(1, 0, 0);
        send(1, 0, 3);
        send(1, 0, 65535);
        send(1, 0, 4);
        send(1, 0, 4);
        send(0, 1, 0);
        send(0, 4000, 0);
        send(0, 100, 0);
        send(1, 0, 4);
        send(1, 0, 16);
        write_limit(16);
        send(0, 5000, 0);
        send(0, 60000, 0);
        send(0, 40000, 0);
        send(1, 0, 4);
        for (int ph = 0; ph < 4; ph++)
        begin
            write_limit(lims[ph]);
            for (int i = 0; i < 420; i++)
            begin
                idle_on = !(ph == 1 && i >= 50 && i < 300);
                if (ph == 2 && i == 100) hold_left = 400;
                random_item();
            end
        end
        in_valid <= 0;
        while (sb.replies.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
